@@ sv/acrc_pkg.sv @@
// Package for the ASCII CRC-32 sentence checker.
// Holds the beat structs, verdict codes, character constants and the CRC fold.
// No dependencies.
package acrc_pkg;

  // Reflected CRC-32 polynomial
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Characters of interest
  localparam logic [7:0] CHR_NUL   = 8'h00;
  localparam logic [7:0] CHR_STAR  = 8'h2A;
  localparam logic [7:0] CHR_0     = 8'h30;
  localparam logic [7:0] CHR_9     = 8'h39;
  localparam logic [7:0] CHR_A_LC  = 8'h61;
  localparam logic [7:0] CHR_F_LC  = 8'h66;
  localparam logic [7:0] HEX_LC_OFS = 8'h57;

  // Verdict codes
  localparam logic [1:0] STS_MATCH    = 2'd0;
  localparam logic [1:0] STS_MISMATCH = 2'd1;
  localparam logic [1:0] STS_TRUNC    = 2'd2;
  localparam logic [1:0] STS_BAD_HEX  = 2'd3;

  // Number of hex digits in the trailer, minus one
  localparam logic [2:0] DIGIT_LAST = 3'd7;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       message_start;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] computed_crc;
    logic [31:0] received_crc;
  } out_beat_t;

  // Sentence phase, one-hot
  typedef enum logic [2:0] {
    PH_IDLE   = 3'b001,
    PH_BODY   = 3'b010,
    PH_DIGITS = 3'b100
  } phase_e;

  // Fold one byte into the CRC, eight bit steps unrolled
  function automatic logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

@@ sv/ascii_crc32_sentence_checker.sv @@
// Top level of the ASCII CRC-32 sentence checker.
// Depends on acrc_pkg (beat structs, codes, CRC fold).
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_beat_i) takes one sentence
//   byte per beat; message_start marks the first byte after the leading '#'.
//   Bytes up to '*' are folded into a reflected CRC-32 (poly 0xEDB88320,
//   zero init, no final xor). The eight lowercase hex digits after '*' are
//   collected and one verdict beat leaves on the output channel
//   (out_valid_o / out_stall_i / out_beat_o). A NUL in the body gives a
//   truncated verdict at once; a non-hex digit gives a bad-digit verdict.
//   Throughput: one byte per cycle while the output is not stalled. The byte goes through an
//   input register, then one bytewise CRC step (eight unrolled bit steps)
//   and the digit logic into the output register.
//   Verdict path: the byte that ends the sentence passes the input register,
//   then the output register, from which the verdict is presented.
//   Stall: while the output register holds a verdict that is stalled, the
//   input register drains no further and in_stall_o rises once it is full.
//   Reset: asynchronous, clears the phase to idle and empties both registers.
module ascii_crc32_sentence_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  acrc_pkg::in_beat_t  in_beat_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output acrc_pkg::out_beat_t out_beat_o
);
  import acrc_pkg::*;

  // Input register
  logic      s1_valid_q;
  in_beat_t  s1_beat_q;

  // Sentence state
  phase_e      phase_q, phase_d;
  logic [31:0] crc_q, crc_d;
  logic [31:0] rcv_q, rcv_d;
  logic [2:0]  digit_cnt_q, digit_cnt_d;
  logic        bad_q, bad_d;

  // Output register
  logic      out_valid_q;
  out_beat_t out_beat_q;

  // Result of the current byte
  logic      res_valid;
  out_beat_t res_beat;

  logic advance;
  logic in_accept;
  logic [3:0] nib;
  logic       nib_ok;

  // The held byte moves on when the output register can take a verdict
  assign advance    = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Hex digit decode
  always_comb begin
    nib    = 4'h0;
    nib_ok = 1'b0;
    if (s1_beat_q.data_byte >= CHR_0 && s1_beat_q.data_byte <= CHR_9) begin
      nib    = 4'(s1_beat_q.data_byte - CHR_0);
      nib_ok = 1'b1;
    end else if (s1_beat_q.data_byte >= CHR_A_LC && s1_beat_q.data_byte <= CHR_F_LC) begin
      nib    = 4'(s1_beat_q.data_byte - HEX_LC_OFS);
      nib_ok = 1'b1;
    end
  end

  // Per-byte sentence logic
  always_comb begin
    phase_d     = phase_q;
    crc_d       = crc_q;
    rcv_d       = rcv_q;
    digit_cnt_d = digit_cnt_q;
    bad_d       = bad_q;
    res_valid   = 1'b0;
    res_beat    = '0;

    // A start byte drops any sentence in progress
    if (s1_beat_q.message_start) begin
      phase_d     = PH_BODY;
      crc_d       = '0;
      rcv_d       = '0;
      digit_cnt_d = '0;
      bad_d       = 1'b0;
    end

    unique case (phase_d)
      PH_BODY: begin
        if (s1_beat_q.data_byte == CHR_NUL) begin
          res_valid             = 1'b1;
          res_beat.status       = STS_TRUNC;
          res_beat.computed_crc = crc_d;
          res_beat.received_crc = '0;
          phase_d               = PH_IDLE;
        end else if (s1_beat_q.data_byte == CHR_STAR) begin
          phase_d     = PH_DIGITS;
          rcv_d       = '0;
          digit_cnt_d = '0;
          bad_d       = 1'b0;
        end else begin
          crc_d = crc_fold(crc_d, s1_beat_q.data_byte);
        end
      end
      PH_DIGITS: begin
        rcv_d = {rcv_d[27:0], nib};
        bad_d = bad_d || !nib_ok;
        if (digit_cnt_d == DIGIT_LAST) begin
          res_valid = 1'b1;
          if (bad_d) begin
            res_beat.status = STS_BAD_HEX;
          end else if (rcv_d == crc_d) begin
            res_beat.status = STS_MATCH;
          end else begin
            res_beat.status = STS_MISMATCH;
          end
          res_beat.computed_crc = crc_d;
          res_beat.received_crc = rcv_d;
          phase_d               = PH_IDLE;
          digit_cnt_d           = '0;
        end else begin
          digit_cnt_d = digit_cnt_d + 3'd1;
        end
      end
      default: begin
        // idle, and codes that never arise: byte ignored
        phase_d = PH_IDLE;
      end
    endcase
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_beat_q <= in_beat_i;
    end
  end

  // Sentence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      crc_q       <= '0;
      rcv_q       <= '0;
      digit_cnt_q <= '0;
      bad_q       <= 1'b0;
    end else if (advance) begin
      phase_q     <= phase_d;
      crc_q       <= crc_d;
      rcv_q       <= rcv_d;
      digit_cnt_q <= digit_cnt_d;
      bad_q       <= bad_d;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_beat_q <= res_beat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  // Checks
  a_empty_no_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> !in_stall_o)
    else $error("input stalled with empty input register");

  a_match_equal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == STS_MATCH) |->
      (out_beat_o.computed_crc == out_beat_o.received_crc))
    else $error("match verdict with differing CRC values");

  a_trunc_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_beat_o.status == STS_TRUNC) |-> (out_beat_o.received_crc == '0))
    else $error("truncated verdict carries a received CRC");

  a_cnt_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q != PH_DIGITS) |-> (digit_cnt_q == '0))
    else $error("digit count nonzero outside the digit phase");

endmodule
